/* hdl/bounded_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// Bounded priority queue assertion macros
// Shared concurrent assertion forms used by the verification checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_DEFINES_SVH

// A property that must hold in the same cycle.
`define BPQ_ASSERT_NOW(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define BPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Beat layouts, register indexes, opcodes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int S_TDATA_W   = 88;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 176;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_CAPACITY_LIMIT = 1'b0;
    localparam cfg_index_t REG_HIGHEST_PRIO   = 1'b1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic shift_step;
        logic scan_read;
        logic insert_next;
        logic place_head;
        logic pop_head;
        logic read_head;
        logic read_tail;
        logic grab_head;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_pop;
        logic count_zero;
        logic full;
        logic shift_needed;
        logic idx_zero;
    } sts_t;

endpackage

/* hdl/bpq_datapath.sv */
// ----------------------------------------------------------------------------
// Bounded priority queue datapath
// Slot memory kept as a ring, item registers, configuration and result beat.
// ----------------------------------------------------------------------------
module bpq_datapath #(
    parameter int CAPACITY       = 128,
    parameter int DATA_WIDTH     = 64,
    parameter int PRIORITY_WIDTH = 15
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bpq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [bpq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic [bpq_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  bpq_pkg::cfg_index_t            cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  bpq_pkg::cmd_t                  cmd,
    output bpq_pkg::sts_t                  sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 8) ? CW : 8;
    localparam int WW = DATA_WIDTH + PRIORITY_WIDTH;

    localparam logic [AW:0]   CAP_A    = (AW + 1)'(CAPACITY);
    localparam logic [LW-1:0] CAP_L    = LW'(CAPACITY);
    localparam logic [31:0]   PRIO_MAX = 32'((64'd1 << PRIORITY_WIDTH) - 64'd1);

    logic [WW-1:0]             mem [CAPACITY];
    logic [WW-1:0]             rd_data_reg;
    logic [WW-1:0]             head_word_reg;
    logic [7:0]                cap_limit_reg;
    logic [14:0]               hpn_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [DATA_WIDTH-1:0]     item_value_reg;
    logic [PRIORITY_WIDTH-1:0] item_prio_reg, item_prio_next;
    logic                      item_op_reg;
    logic                      ok_reg, ok_next;
    logic [bpq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [15:0]   in_prio;
    logic [16:0]   in_mag;
    logic [31:0]   hpn_ext, clamp_ext, mag_ext, prio_ext;
    logic [LW-1:0] limit_ext, eff_limit, count_ext;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_log, idx_p1, rd_log, wr_log;
    logic          rd_en, wr_en, full;
    logic [WW-1:0] new_word, wr_data;

    logic [CW+7:0]             cnt_wide;
    logic [DATA_WIDTH+63:0]    hv_wide, tv_wide;
    logic [PRIORITY_WIDTH+15:0] hp_wide, tp_wide;
    logic [63:0]               head_value, tail_value;
    logic [15:0]               head_prio, tail_prio;
    logic [7:0]                cnt_out;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, l};
        if (s >= CAP_A) begin
            s = s - CAP_A;
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        in_prio   = s_tdata[79:64];
        in_mag    = in_prio[15] ? (17'h10000 - {1'b0, in_prio}) : {1'b0, in_prio};
        hpn_ext   = {17'b0, hpn_reg};
        clamp_ext = (hpn_ext > PRIO_MAX) ? PRIO_MAX : hpn_ext;
        mag_ext   = {15'b0, in_mag};
        if (s_tdata[80]) begin
            prio_ext = clamp_ext;
        end else begin
            prio_ext = (mag_ext > clamp_ext) ? clamp_ext : mag_ext;
        end
        item_prio_next = prio_ext[PRIORITY_WIDTH-1:0];
    end

    always_comb begin
        limit_ext = LW'(cap_limit_reg);
        eff_limit = (limit_ext > CAP_L) ? CAP_L : limit_ext;
        count_ext = LW'(count_reg);
        full      = count_ext >= eff_limit;
        count_m1  = count_reg - 1'b1;
        last_log  = count_m1[AW-1:0];
        idx_p1    = idx_reg + 1'b1;
        new_word  = {item_prio_reg, item_value_reg};
    end

    assign sts.item_pop     = (item_op_reg == bpq_pkg::OP_POP);
    assign sts.count_zero   = (count_reg == '0);
    assign sts.full         = full;
    assign sts.shift_needed = rd_data_reg[WW-1:DATA_WIDTH] > item_prio_reg;
    assign sts.idx_zero     = (idx_reg == '0);

    always_comb begin
        rd_en = cmd.start_scan | cmd.scan_read | cmd.read_head | cmd.read_tail;
        if (cmd.read_head) begin
            rd_log = '0;
        end else if (cmd.scan_read) begin
            rd_log = idx_reg - 1'b1;
        end else begin
            rd_log = last_log;
        end
        wr_en   = cmd.shift_step | cmd.insert_next | cmd.place_head;
        wr_log  = cmd.place_head ? '0 : idx_p1;
        wr_data = cmd.shift_step ? rd_data_reg : new_word;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[phys(head_reg, wr_log)] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[phys(head_reg, rd_log)];
        end
    end

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        if (cmd.capture) begin
            ok_next = 1'b0;
        end
        if (cmd.start_scan) begin
            idx_next = last_log;
        end
        if (cmd.shift_step) begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.insert_next || cmd.place_head) begin
            count_next = count_reg + 1'b1;
            ok_next    = 1'b1;
        end
        if (cmd.pop_head) begin
            head_next  = phys(head_reg, AW'(1));
            count_next = count_reg - 1'b1;
            ok_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            ok_reg        <= 1'b0;
            cap_limit_reg <= 8'd100;
            hpn_reg       <= 15'd2048;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            ok_reg    <= ok_next;
            if (cfg_we) begin
                case (cfg_index)
                    bpq_pkg::REG_CAPACITY_LIMIT: begin
                        cap_limit_reg <= cfg_wdata[7:0];
                    end
                    bpq_pkg::REG_HIGHEST_PRIO: begin
                        hpn_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_value_reg <= s_tdata[DATA_WIDTH-1:0];
            item_prio_reg  <= item_prio_next;
            item_op_reg    <= s_tuser[0];
        end
        if (cmd.grab_head) begin
            head_word_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_comb begin
        cnt_wide = {8'b0, count_reg};
        hv_wide  = {64'b0, head_word_reg[DATA_WIDTH-1:0]};
        tv_wide  = {64'b0, rd_data_reg[DATA_WIDTH-1:0]};
        hp_wide  = {16'b0, head_word_reg[WW-1:DATA_WIDTH]};
        tp_wide  = {16'b0, rd_data_reg[WW-1:DATA_WIDTH]};
        cnt_out  = cnt_wide[7:0];
        if (sts.count_zero) begin
            head_value = '0;
            tail_value = '0;
            head_prio  = 16'hFFFF;
            tail_prio  = 16'hFFFF;
        end else begin
            head_value = hv_wide[63:0];
            tail_value = tv_wide[63:0];
            head_prio  = hp_wide[15:0];
            tail_prio  = tp_wide[15:0];
        end
        m_tdata_next = {5'b0, tail_prio, tail_value, head_prio, head_value,
                        full, sts.count_zero, cnt_out, ok_reg};
    end

    assign m_tdata = m_tdata_reg;

endmodule

/* hdl/bpq_controller.sv */
// ----------------------------------------------------------------------------
// Bounded priority queue controller
// Sequences accept, insertion scan, head pop, head/tail readout and result.
// ----------------------------------------------------------------------------
module bpq_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  bpq_pkg::sts_t sts,
    output bpq_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DECIDE    = 7'b0000010,
        ST_SCAN      = 7'b0000100,
        ST_PLACE     = 7'b0001000,
        ST_LOAD_HEAD = 7'b0010000,
        ST_LOAD_TAIL = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.item_pop) begin
                    cmd.pop_head = !sts.count_zero;
                    state_next   = ST_LOAD_HEAD;
                end else if (sts.full) begin
                    state_next = ST_LOAD_HEAD;
                end else if (sts.count_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.shift_needed) begin
                    cmd.shift_step = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = ST_PLACE;
                    end else begin
                        cmd.scan_read = 1'b1;
                    end
                end else begin
                    cmd.insert_next = 1'b1;
                    state_next      = ST_LOAD_HEAD;
                end
            end
            ST_PLACE: begin
                cmd.place_head = 1'b1;
                state_next     = ST_LOAD_HEAD;
            end
            ST_LOAD_HEAD: begin
                if (sts.count_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.read_head = 1'b1;
                    state_next    = ST_LOAD_TAIL;
                end
            end
            ST_LOAD_TAIL: begin
                cmd.read_tail = 1'b1;
                cmd.grab_head = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

/* hdl/bounded_priority_queue.sv */
// ----------------------------------------------------------------------------
// Bounded priority queue
// Sorted queue of data words with priorities; smallest number leaves first.
//
//   Channel   Direction   Beat contents
//   s_        in          push or pop request
//   m_        out         acceptance, count, flags, head and tail entries
//   cfg_      in          register writes, no read-back
//
// A pop steps through accept, decide, head read, tail read and result; the tail read is
// skipped when it finds or leaves the queue empty. A push scans past each held entry it
// is placed ahead of, set by the single read port of the slot memory that moves one entry
// a cycle. A refused push skips the scan, and also the tail read when the queue is empty.
// A new beat is taken while an earlier result still waits on m_tready.
// Reset empties the queue at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_priority_queue #(
    parameter int CAPACITY       = 128,
    parameter int DATA_WIDTH     = 64,
    parameter int PRIORITY_WIDTH = 15
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value_bits[63:0], priority_in[79:64], use_default[80], zero fill
    input  logic [bpq_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic [bpq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted[0], entry_count[8:1], is_empty_flag[9], is_full_flag[10],
    // head_value[74:11], head_priority[90:75], tail_value[154:91],
    // tail_priority[170:155], zero fill
    output logic [bpq_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  bpq_pkg::cfg_index_t            cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    bpq_pkg::cmd_t cmd;
    bpq_pkg::sts_t sts;

    bpq_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpq_datapath #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* hdl/bpq_checker.sv */
// ----------------------------------------------------------------------------
// Bounded priority queue checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "bounded_priority_queue_defines.svh"

module bpq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpq_pkg::M_TDATA_W-1:0] m_tdata
);

    `BPQ_ASSERT_NEXT(a_out_valid_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `BPQ_ASSERT_NEXT(a_out_data_held, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")
    `BPQ_ASSERT_NEXT(a_one_request, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken before the first was done")
    `BPQ_ASSERT_NOW(a_empty_fields, aclk, aresetn, (m_tvalid && m_tdata[9]) |-> (m_tdata[8:1] == 8'd0 && m_tdata[90:75] == 16'hFFFF && m_tdata[170:155] == 16'hFFFF && m_tdata[74:11] == 64'd0 && m_tdata[154:91] == 64'd0), "empty result carries entry fields")

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (.*);

/* tb/bounded_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded priority queue testbench
// Sends push and pop request beats with random gaps and random result
// back-pressure, including long hold-offs that fill the block. A shadow copy
// of the sorted queue predicts every result beat, and each one is compared
// field by field. The capacity limit and the priority clamp are changed
// between phases, with both extremes among the settings.
// ----------------------------------------------------------------------------
module bounded_priority_queue_tb;

    localparam int QUEUE_DEPTH  = 128;
    localparam int REPORT_LIMIT = 10;
    localparam int CFG_W        = bpq_pkg::CFG_DATA_W;

    typedef struct {
        logic        op;
        logic [63:0] value;
        logic [15:0] prio;
        logic        use_default;
    } queue_request_t;

    typedef struct {
        logic        accepted;
        logic [7:0]  count;
        logic        empty;
        logic        full;
        logic [63:0] head_value;
        logic [15:0] head_prio;
        logic [63:0] tail_value;
        logic [15:0] tail_prio;
    } queue_status_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bpq_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [bpq_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bpq_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_we    = 1'b0;
    bpq_pkg::cfg_index_t            cfg_index = bpq_pkg::REG_CAPACITY_LIMIT;
    logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [63:0] shadow_value [QUEUE_DEPTH];
    logic [14:0] shadow_prio [QUEUE_DEPTH];
    int          shadow_count;
    logic [7:0]  shadow_limit;
    logic [14:0] shadow_clamp;

    queue_request_t pending_requests[$];
    queue_status_t  expected_status[$];

    int requests_queued;
    int requests_taken;
    int mismatches;
    int pushes_done;
    int pops_done;
    int refusals;
    int peak_count;
    int settings_written;
    int max_send_gap;
    int max_recv_gap;
    bit hold_results;
    bit s_beat_taken;
    bit m_beat_taken;

    bounded_priority_queue #(
        .CAPACITY       (QUEUE_DEPTH),
        .DATA_WIDTH     (64),
        .PRIORITY_WIDTH (15)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic queue_status_t predict_queue_step(queue_request_t req);
        queue_status_t st;
        int          room;
        int          pos;
        logic [16:0] mag;
        logic [14:0] pri;
        room = (shadow_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_limit;
        st.accepted = 1'b0;
        if (req.op == bpq_pkg::OP_PUSH) begin
            if (req.use_default) begin
                pri = shadow_clamp;
            end else begin
                mag = req.prio[15] ? (17'h10000 - {1'b0, req.prio}) : {1'b0, req.prio};
                pri = (mag > shadow_clamp) ? shadow_clamp : mag[14:0];
            end
            if (shadow_count < room) begin
                // The new entry goes behind every entry of equal or smaller number.
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= pri) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = req.value;
                shadow_prio[pos]  = pri;
                shadow_count++;
                st.accepted = 1'b1;
            end
        end else if (shadow_count > 0) begin
            for (int i = 1; i < shadow_count; i++) begin
                shadow_value[i-1] = shadow_value[i];
                shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_count--;
            st.accepted = 1'b1;
        end
        st.count = shadow_count[7:0];
        st.empty = (shadow_count == 0);
        st.full  = (shadow_count >= room);
        if (shadow_count == 0) begin
            st.head_value = '0;
            st.head_prio  = 16'hFFFF;
            st.tail_value = '0;
            st.tail_prio  = 16'hFFFF;
        end else begin
            st.head_value = shadow_value[0];
            st.head_prio  = {1'b0, shadow_prio[0]};
            st.tail_value = shadow_value[shadow_count-1];
            st.tail_prio  = {1'b0, shadow_prio[shadow_count-1]};
        end
        return st;
    endfunction

    function automatic queue_status_t unpack_status(logic [bpq_pkg::M_TDATA_W-1:0] d);
        queue_status_t st;
        st.accepted   = d[0];
        st.count      = d[8:1];
        st.empty      = d[9];
        st.full       = d[10];
        st.head_value = d[74:11];
        st.head_prio  = d[90:75];
        st.tail_value = d[154:91];
        st.tail_prio  = d[170:155];
        return st;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        queue_request_t req;
        queue_status_t  want;
        queue_status_t  got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req.op          = s_tuser[0];
                req.value       = s_tdata[63:0];
                req.prio        = s_tdata[79:64];
                req.use_default = s_tdata[80];
                want = predict_queue_step(req);
                if (!want.accepted) refusals++;
                else if (req.op == bpq_pkg::OP_PUSH) pushes_done++;
                else pops_done++;
                if (want.count > peak_count) peak_count = want.count;
                expected_status.push_back(want);
                requests_taken++;
                s_beat_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = unpack_status(m_tdata);
                m_beat_taken = 1'b1;
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t ns: result beat with nothing expected, tdata %h",
                                 $time, m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("entry_count", want.count, got.count);
                    compare_field("is_empty_flag", want.empty, got.empty);
                    compare_field("is_full_flag", want.full, got.full);
                    compare_field("head_value", want.head_value, got.head_value);
                    compare_field("head_priority", want.head_prio, got.head_prio);
                    compare_field("tail_value", want.tail_value, got.tail_value);
                    compare_field("tail_priority", want.tail_prio, got.tail_prio);
                end
            end
        end
    end

    always @(negedge aclk) begin : request_driver
        bit             offering;
        int             send_wait;
        queue_request_t next_req;
        if (s_beat_taken) begin
            s_beat_taken = 1'b0;
            offering     = 1'b0;
            send_wait    = $urandom_range(0, max_send_gap);
        end
        if (!offering && aresetn) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (pending_requests.size() > 0) begin
                next_req = pending_requests.pop_front();
                offering = 1'b1;
                s_tdata <= {{(bpq_pkg::S_TDATA_W-81){1'b0}}, next_req.use_default,
                            next_req.prio, next_req.value};
                s_tuser <= next_req.op;
            end
        end
        s_tvalid <= offering;
    end

    always @(negedge aclk) begin : result_receiver
        int recv_wait;
        if (m_beat_taken) begin
            m_beat_taken = 1'b0;
            recv_wait    = $urandom_range(0, max_recv_gap);
        end
        if (hold_results || !aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_request(logic op, logic [63:0] value, logic [15:0] prio,
                               logic use_default);
        queue_request_t req;
        req.op          = op;
        req.value       = value;
        req.prio        = prio;
        req.use_default = use_default;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic add_random_requests(int n, int push_pct, int span);
        logic [15:0] prio;
        int          style;
        repeat (n) begin
            style = $urandom_range(0, 9);
            if (style <= 2) begin
                prio = 16'($urandom);
            end else begin
                prio = 16'($urandom_range(0, span));
                if ($urandom_range(0, 1)) prio = -prio;
            end
            add_request(($urandom_range(0, 99) < push_pct) ? bpq_pkg::OP_PUSH
                                                          : bpq_pkg::OP_POP,
                        {$urandom, $urandom}, prio, style == 0);
        end
    endtask

    task automatic wait_until_idle();
        while (requests_taken != requests_queued || expected_status.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(bpq_pkg::cfg_index_t idx,
                                  logic [bpq_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == bpq_pkg::REG_CAPACITY_LIMIT) shadow_limit = data[7:0];
        else shadow_clamp = data[14:0];
        settings_written++;
    endtask

    task automatic configure(int limit, int clamp);
        write_register(bpq_pkg::REG_CAPACITY_LIMIT, CFG_W'(limit));
        write_register(bpq_pkg::REG_HIGHEST_PRIO, CFG_W'(clamp));
    endtask

    initial begin : stimulus
        max_send_gap = 10;
        max_recv_gap = 10;
        shadow_count = 0;
        shadow_limit = 8'd100;
        shadow_clamp = 15'd2048;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings: a pop on the empty queue,
        // field extremes, clamping, default pushes and ties in arrival order.
        add_request(bpq_pkg::OP_POP, 64'h0, 16'h0000, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h0, 16'h0000, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'hA5A5_5A5A_C3C3_3C3C, 16'h7FFF, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h0123_4567_89AB_CDEF, 16'h0005, 1'b1);
        add_request(bpq_pkg::OP_PUSH, 64'h1, 16'hFFFF, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h2, 16'h0001, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h3, 16'd2047, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h4, 16'hF800, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h5, 16'd2049, 1'b0);
        add_request(bpq_pkg::OP_PUSH, 64'h6, 16'd2048, 1'b0);
        repeat (11) add_request(bpq_pkg::OP_POP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        wait_until_idle();

        configure(4, 32767);
        add_random_requests(60, 60, 7);
        wait_until_idle();

        configure(1, 0);
        add_random_requests(40, 50, 3);
        wait_until_idle();

        // Back-to-back beats on both sides while the queue fills.
        configure(128, 7);
        max_send_gap = 0;
        max_recv_gap = 0;
        add_random_requests(120, 90, 7);
        wait_until_idle();

        // The receiver holds off while requests keep coming, so the input stalls.
        max_send_gap = 2;
        max_recv_gap = 10;
        add_random_requests(160, 85, 7);
        @(posedge aclk);
        hold_results = 1'b1;
        repeat (400) @(posedge aclk);
        hold_results = 1'b0;
        @(negedge aclk);
        wait_until_idle();

        // The limit drops under the count, so pushes are refused until pops catch up.
        max_send_gap = 10;
        configure(120, 7);
        add_random_requests(40, 25, 7);
        wait_until_idle();

        configure(255, 1000);
        add_random_requests(120, 55, 2000);
        wait_until_idle();

        configure(0, 2048);
        add_random_requests(20, 50, 100);
        wait_until_idle();

        configure(16, $urandom_range(0, 32767));
        add_random_requests(120, 50, 32767);
        wait_until_idle();

        configure(100, 2048);
        add_random_requests(60, 90, 3000);
        wait_until_idle();

        // A lower clamp while entries are held puts default pushes mid-queue.
        write_register(bpq_pkg::REG_HIGHEST_PRIO, CFG_W'(5));
        add_random_requests(80, 50, 20);
        wait_until_idle();

        repeat (20) @(negedge aclk);
        $display("Sent %0d request beats: %0d pushes and %0d pops taken, %0d refused.",
                 requests_taken, pushes_done, pops_done, refusals);
        $display("Peak depth %0d entries across %0d register writes.",
                 peak_count, settings_written);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
